// ----- rtl/axis_angle_vector_rotate_defines.svh -----
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_defines
// assertion macros shared by the axis-angle rotator
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define AAVR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition that must never be seen outside reset
`define AAVR_ASSERT_NEVER(label, bad) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error("forbidden condition seen");

`endif

// ----- rtl/aavr_pkg.sv -----
// ----------------------------------------------------------------------------
// aavr_pkg
// types, constants and tables of the axis-angle rotator
// ----------------------------------------------------------------------------
package aavr_pkg;

    localparam int COORD_W   = 32;
    localparam int UNIT_BITS = ((61 - COORD_W) < 30) ? (61 - COORD_W) : 30;
    localparam int MAG_W     = 30;
    localparam int SUM_W     = 62;
    localparam int NORM_W    = 31;
    localparam int UNIT_W    = 31;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef logic [MAG_W-1:0]          mag_val_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        mag_val_t x;
        mag_val_t y;
        mag_val_t z;
    } mag_t;

    typedef struct packed {
        unit_t x;
        unit_t y;
        unit_t z;
    } unit_vec_t;

    // side data that rides along the axis normalization
    typedef struct packed {
        vec_t       a;
        logic [2:0] bneg;
        logic       zero;
        coord_t     cs;
        coord_t     sn;
    } carry_t;

    localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
    localparam logic [63:0] GAIN_RND = 64'd1 << (32 - UNIT_BITS - 1);
    localparam coord_t CORDIC_X0 = coord_t'((GAIN_Q32 + GAIN_RND) >> (32 - UNIT_BITS));

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // arctangent of 2^-i in turns, 2^32 per turn
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/aavr_cordic.sv -----
// ----------------------------------------------------------------------------
// aavr_cordic
// pipelined rotation-mode cordic giving cosine and sine of the angle
// ----------------------------------------------------------------------------
module aavr_cordic #(
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [ANGLE_WIDTH-1:0]  turn,
    input  aavr_pkg::vec_t          a_in,
    input  aavr_pkg::vec_t          b_in,
    output logic                    out_valid,
    output aavr_pkg::vec_t          a_out,
    output aavr_pkg::vec_t          b_out,
    output aavr_pkg::coord_t        cs,
    output aavr_pkg::coord_t        sn
);

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic                v_reg    [0:CORDIC_STEPS];
    aavr_pkg::coord_t    x_reg    [0:CORDIC_STEPS];
    aavr_pkg::coord_t    y_reg    [0:CORDIC_STEPS];
    aavr_pkg::coord_t    z_reg    [0:CORDIC_STEPS];
    logic [1:0]          quad_reg [0:CORDIC_STEPS];
    aavr_pkg::vec_t      a_reg    [0:CORDIC_STEPS];
    aavr_pkg::vec_t      b_reg    [0:CORDIC_STEPS];

    logic [31:0]         t_full;
    logic                out_v_reg;
    aavr_pkg::coord_t    cs_reg;
    aavr_pkg::coord_t    sn_reg;
    aavr_pkg::coord_t    cs_next;
    aavr_pkg::coord_t    sn_next;
    aavr_pkg::vec_t      a_o_reg;
    aavr_pkg::vec_t      b_o_reg;

    assign t_full = {turn, {(32-ANGLE_WIDTH){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= aavr_pkg::CORDIC_X0;
        y_reg[0]    <= '0;
        z_reg[0]    <= aavr_pkg::coord_t'({2'b00, t_full[29:0]});
        quad_reg[0] <= t_full[31:30];
        a_reg[0]    <= a_in;
        b_reg[0]    <= b_in;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        localparam aavr_pkg::coord_t AT = aavr_pkg::coord_t'(aavr_pkg::atan_turn(k));
        aavr_pkg::coord_t dx;
        aavr_pkg::coord_t dy;

        assign dx = x_reg[k] >>> k;
        assign dy = y_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!z_reg[k][31])
            begin
                x_reg[k+1] <= x_reg[k] - dy;
                y_reg[k+1] <= y_reg[k] + dx;
                z_reg[k+1] <= z_reg[k] - AT;
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + dy;
                y_reg[k+1] <= y_reg[k] - dx;
                z_reg[k+1] <= z_reg[k] + AT;
            end
            quad_reg[k+1] <= quad_reg[k];
            a_reg[k+1]    <= a_reg[k];
            b_reg[k+1]    <= b_reg[k];
        end
    end

    // dx above carries the shifted x term, dy the shifted y term
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            QUAD_FIRST:
            begin
                cs_next = x_reg[CORDIC_STEPS];
                sn_next = y_reg[CORDIC_STEPS];
            end
            QUAD_SECOND:
            begin
                cs_next = -y_reg[CORDIC_STEPS];
                sn_next = x_reg[CORDIC_STEPS];
            end
            QUAD_THIRD:
            begin
                cs_next = -x_reg[CORDIC_STEPS];
                sn_next = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                cs_next = y_reg[CORDIC_STEPS];
                sn_next = -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg  <= cs_next;
        sn_reg  <= sn_next;
        a_o_reg <= a_reg[CORDIC_STEPS];
        b_o_reg <= b_reg[CORDIC_STEPS];
    end

    assign out_valid = out_v_reg;
    assign cs        = cs_reg;
    assign sn        = sn_reg;
    assign a_out     = a_o_reg;
    assign b_out     = b_o_reg;

endmodule

// ----- rtl/aavr_norm.sv -----
// ----------------------------------------------------------------------------
// aavr_norm
// axis magnitudes, block normalization and sum of squares
// ----------------------------------------------------------------------------
module aavr_norm (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  aavr_pkg::vec_t           a_in,
    input  aavr_pkg::vec_t           b_in,
    input  aavr_pkg::coord_t         cs,
    input  aavr_pkg::coord_t         sn,
    output logic                     out_valid,
    output aavr_pkg::carry_t         carry_out,
    output aavr_pkg::mag_t           mag_out,
    output logic [aavr_pkg::SUM_W-1:0] sum_out
);

    localparam int SQ_W = 2 * aavr_pkg::MAG_W;

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    logic               v_reg [0:4];
    aavr_pkg::carry_t   c_reg [0:4];

    logic [31:0]        m1_reg [0:2];
    logic [31:0]        mx1_reg;
    logic [31:0]        m2_reg [0:2];
    logic               right2_reg;
    logic [4:0]         amt2_reg;
    aavr_pkg::mag_val_t m3_reg [0:2];
    aavr_pkg::mag_val_t m4_reg [0:2];
    logic [SQ_W-1:0]    sq4_reg [0:2];
    aavr_pkg::mag_val_t m5_reg [0:2];
    logic [aavr_pkg::SUM_W-1:0] sum5_reg;

    aavr_pkg::coord_t   b_arr [0:2];
    logic [31:0]        m_abs [0:2];
    logic [31:0]        mx_next;
    logic [5:0]         lz;

    assign b_arr[0] = b_in.x;
    assign b_arr[1] = b_in.y;
    assign b_arr[2] = b_in.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_abs[i] = b_arr[i][31] ? 32'(-b_arr[i]) : 32'(b_arr[i]);
        end
        mx_next = m_abs[0];
        if (m_abs[1] > mx_next)
        begin
            mx_next = m_abs[1];
        end
        if (m_abs[2] > mx_next)
        begin
            mx_next = m_abs[2];
        end
    end

    assign lz = lead_zeros(mx1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < 5; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0].a    <= a_in;
        c_reg[0].bneg <= {b_in.x[31], b_in.y[31], b_in.z[31]};
        c_reg[0].zero <= (b_in.x == '0) && (b_in.y == '0) && (b_in.z == '0);
        c_reg[0].cs   <= cs;
        c_reg[0].sn   <= sn;
        for (int s = 1; s < 5; s++)
        begin
            c_reg[s] <= c_reg[s-1];
        end

        // magnitudes and their maximum
        for (int i = 0; i < 3; i++)
        begin
            m1_reg[i] <= m_abs[i];
        end
        mx1_reg <= mx_next;

        // shift that brings the largest into [2^29, 2^30)
        for (int i = 0; i < 3; i++)
        begin
            m2_reg[i] <= m1_reg[i];
        end
        right2_reg <= mx1_reg[31] | mx1_reg[30];
        if (mx1_reg[31])
        begin
            amt2_reg <= 5'd2;
        end
        else if (mx1_reg[30])
        begin
            amt2_reg <= 5'd1;
        end
        else
        begin
            amt2_reg <= 5'(lz - 6'd2);
        end

        for (int i = 0; i < 3; i++)
        begin
            if (right2_reg)
            begin
                m3_reg[i] <= aavr_pkg::MAG_W'(m2_reg[i] >> amt2_reg);
            end
            else
            begin
                m3_reg[i] <= aavr_pkg::MAG_W'(m2_reg[i] << amt2_reg);
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            sq4_reg[i] <= SQ_W'(m3_reg[i]) * SQ_W'(m3_reg[i]);
            m4_reg[i]  <= m3_reg[i];
        end

        sum5_reg <= aavr_pkg::SUM_W'(sq4_reg[0]) + aavr_pkg::SUM_W'(sq4_reg[1])
                  + aavr_pkg::SUM_W'(sq4_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            m5_reg[i] <= m4_reg[i];
        end
    end

    assign out_valid = v_reg[4];
    assign carry_out = c_reg[4];
    assign mag_out   = '{x: m5_reg[0], y: m5_reg[1], z: m5_reg[2]};
    assign sum_out   = sum5_reg;

endmodule

// ----- rtl/aavr_isqrt.sv -----
// ----------------------------------------------------------------------------
// aavr_isqrt
// bitwise integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module aavr_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [aavr_pkg::SUM_W-1:0]    sum_in,
    input  aavr_pkg::carry_t              carry_in,
    input  aavr_pkg::mag_t                mag_in,
    output logic                          out_valid,
    output logic [aavr_pkg::NORM_W-1:0]   nrm,
    output aavr_pkg::carry_t              carry_out,
    output aavr_pkg::mag_t                mag_out
);

    localparam int STAGES = 32;
    localparam int W      = 63;

    logic             v_reg   [0:STAGES-1];
    logic [W-1:0]     s_reg   [0:STAGES-1];
    logic [W-1:0]     res_reg [0:STAGES-1];
    aavr_pkg::carry_t c_reg   [0:STAGES-1];
    aavr_pkg::mag_t   m_reg   [0:STAGES-1];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (62 - 2 * k);
        logic             v_in;
        logic [W-1:0]     s_in;
        logic [W-1:0]     r_in;
        logic [W-1:0]     trial;
        aavr_pkg::carry_t c_in;
        aavr_pkg::mag_t   m_in;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign s_in = W'(sum_in);
            assign r_in = '0;
            assign c_in = carry_in;
            assign m_in = mag_in;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign s_in = s_reg[k-1];
            assign r_in = res_reg[k-1];
            assign c_in = c_reg[k-1];
            assign m_in = m_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (s_in >= trial)
            begin
                s_reg[k]   <= s_in - trial;
                res_reg[k] <= (r_in >> 1) + BIT;
            end
            else
            begin
                s_reg[k]   <= s_in;
                res_reg[k] <= r_in >> 1;
            end
            c_reg[k] <= c_in;
            m_reg[k] <= m_in;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign nrm       = aavr_pkg::NORM_W'(res_reg[STAGES-1]);
    assign carry_out = c_reg[STAGES-1];
    assign mag_out   = m_reg[STAGES-1];

endmodule

// ----- rtl/aavr_div.sv -----
// ----------------------------------------------------------------------------
// aavr_div
// three-lane restoring divider forming the signed unit axis
// ----------------------------------------------------------------------------
module aavr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [aavr_pkg::NORM_W-1:0]   nrm,
    input  aavr_pkg::carry_t              carry_in,
    input  aavr_pkg::mag_t                mag_in,
    output logic                          out_valid,
    output aavr_pkg::carry_t              carry_out,
    output aavr_pkg::unit_vec_t           u
);

    localparam int QB    = 31;
    localparam int NUM_W = aavr_pkg::MAG_W + 31;
    localparam int LAST  = QB;

    logic             v_reg [0:LAST];
    aavr_pkg::carry_t c_reg [0:LAST];
    logic [aavr_pkg::NORM_W-1:0] d_reg [0:LAST];
    logic [NUM_W-1:0] rem_reg [0:LAST][0:2];
    logic [QB-1:0]    quo_reg [0:LAST][0:2];

    aavr_pkg::mag_val_t mag_arr [0:2];
    logic               out_v_reg;
    aavr_pkg::carry_t   c_o_reg;
    aavr_pkg::unit_t    u_reg [0:2];
    logic [29:0]        m_half [0:2];

    assign mag_arr[0] = mag_in.x;
    assign mag_arr[1] = mag_in.y;
    assign mag_arr[2] = mag_in.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    // numerator with half the divisor added for rounding
    always_ff @(posedge clk)
    begin
        c_reg[0] <= carry_in;
        d_reg[0] <= nrm;
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[0][i] <= ({1'b0, mag_arr[i], 30'd0}) + NUM_W'(nrm >> 1);
            quo_reg[0][i] <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        localparam int J = QB - 1 - k;
        logic [NUM_W-1:0] dsh;

        assign dsh = NUM_W'(d_reg[k]) << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            c_reg[k+1] <= c_reg[k];
            d_reg[k+1] <= d_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[k][i] >= dsh)
                begin
                    rem_reg[k+1][i] <= rem_reg[k][i] - dsh;
                    quo_reg[k+1][i] <= {quo_reg[k][i][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1][i] <= rem_reg[k][i];
                    quo_reg[k+1][i] <= {quo_reg[k][i][QB-2:0], 1'b0};
                end
            end
        end
    end

    // round to the unit fraction width, then apply the axis sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_half[i] = 30'((32'(quo_reg[LAST][i]) + 32'd1) >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        c_o_reg <= c_reg[LAST];
        for (int i = 0; i < 3; i++)
        begin
            if (c_reg[LAST].bneg[2-i])
            begin
                u_reg[i] <= -aavr_pkg::unit_t'({1'b0, m_half[i]});
            end
            else
            begin
                u_reg[i] <= aavr_pkg::unit_t'({1'b0, m_half[i]});
            end
        end
    end

    assign out_valid = out_v_reg;
    assign carry_out = c_o_reg;
    assign u         = '{x: u_reg[0], y: u_reg[1], z: u_reg[2]};

endmodule

// ----- rtl/aavr_rot.sv -----
// ----------------------------------------------------------------------------
// aavr_rot
// projection, cross product, sine/cosine blend and saturation
// ----------------------------------------------------------------------------
module aavr_rot (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  aavr_pkg::carry_t      carry_in,
    input  aavr_pkg::unit_vec_t   u_in,
    output logic                  done,
    output aavr_pkg::coord_t      rx,
    output aavr_pkg::coord_t      ry,
    output aavr_pkg::coord_t      rz,
    output logic                  axis_zero,
    output logic                  clipped
);

    localparam int UB     = aavr_pkg::UNIT_BITS;
    localparam int NS     = 13;
    localparam int PA_W   = 63;
    localparam int DR_W   = 35;
    localparam int PP_W   = 64;
    localparam int P_W    = 35;
    localparam int Q_W    = 36;
    localparam int CP_W   = 67;
    localparam int WD_W   = 68;
    localparam int W_W    = 39;
    localparam int QC_W   = 68;
    localparam int WS_W   = 71;
    localparam int TOT_W  = 72;
    localparam int RES_W  = 44;

    logic             v_reg [0:NS-1];
    aavr_pkg::carry_t c_reg [0:NS-1];
    aavr_pkg::unit_t  u_reg [0:5][0:2];

    logic signed [PA_W-1:0]  pa_reg [0:2];
    logic signed [PA_W-1:0]  dot_reg;
    logic signed [DR_W-1:0]  dr_reg;
    logic signed [PP_W-1:0]  pp_reg [0:2];
    logic signed [P_W-1:0]   p_reg  [4:10][0:2];
    logic signed [Q_W-1:0]   q_reg  [5:8][0:2];
    logic signed [CP_W-1:0]  cpa_reg [0:2];
    logic signed [CP_W-1:0]  cpb_reg [0:2];
    logic signed [WD_W-1:0]  wd_reg [0:2];
    logic signed [W_W-1:0]   w_reg  [0:2];
    logic signed [QC_W-1:0]  qc_reg [0:2];
    logic signed [WS_W-1:0]  ws_reg [0:2];
    logic signed [TOT_W-1:0] tot_reg [0:2];
    logic signed [RES_W-1:0] res_reg [0:2];
    aavr_pkg::coord_t        out_reg [0:2];
    logic                    zero_reg;
    logic                    clip_reg;

    aavr_pkg::coord_t        a_in_arr [0:2];
    aavr_pkg::unit_t         u_in_arr [0:2];
    aavr_pkg::coord_t        a4_arr [0:2];
    aavr_pkg::coord_t        a12_arr [0:2];
    aavr_pkg::coord_t        sat_next [0:2];
    logic                    clip_next;

    assign a_in_arr[0] = carry_in.a.x;
    assign a_in_arr[1] = carry_in.a.y;
    assign a_in_arr[2] = carry_in.a.z;
    assign u_in_arr[0] = u_in.x;
    assign u_in_arr[1] = u_in.y;
    assign u_in_arr[2] = u_in.z;
    assign a4_arr[0]   = c_reg[4].a.x;
    assign a4_arr[1]   = c_reg[4].a.y;
    assign a4_arr[2]   = c_reg[4].a.z;
    assign a12_arr[0]  = c_reg[NS-2].a.x;
    assign a12_arr[1]  = c_reg[NS-2].a.y;
    assign a12_arr[2]  = c_reg[NS-2].a.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0] <= carry_in;
        for (int s = 1; s < NS; s++)
        begin
            c_reg[s] <= c_reg[s-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            u_reg[0][i] <= u_in_arr[i];
            for (int s = 1; s < 6; s++)
            begin
                u_reg[s][i] <= u_reg[s-1][i];
            end
        end

        // dot product with the unit axis
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i] <= PA_W'(a_in_arr[i]) * PA_W'(u_in_arr[i]);
        end
        dot_reg <= pa_reg[0] + pa_reg[1] + pa_reg[2];
        dr_reg  <= DR_W'((dot_reg + (PA_W'(1) <<< (UB - 1))) >>> UB);

        // parallel part and perpendicular remainder
        for (int i = 0; i < 3; i++)
        begin
            pp_reg[i]   <= PP_W'(dr_reg) * PP_W'(u_reg[2][i]);
            p_reg[4][i] <= P_W'((pp_reg[i] + (PP_W'(1) <<< (UB - 1))) >>> UB);
            for (int s = 5; s <= 10; s++)
            begin
                p_reg[s][i] <= p_reg[s-1][i];
            end
            q_reg[5][i] <= Q_W'(a4_arr[i]) - Q_W'(p_reg[4][i]);
            for (int s = 6; s <= 8; s++)
            begin
                q_reg[s][i] <= q_reg[s-1][i];
            end
        end

        // u cross q
        cpa_reg[0] <= CP_W'(u_reg[5][1]) * CP_W'(q_reg[5][2]);
        cpb_reg[0] <= CP_W'(u_reg[5][2]) * CP_W'(q_reg[5][1]);
        cpa_reg[1] <= CP_W'(u_reg[5][2]) * CP_W'(q_reg[5][0]);
        cpb_reg[1] <= CP_W'(u_reg[5][0]) * CP_W'(q_reg[5][2]);
        cpa_reg[2] <= CP_W'(u_reg[5][0]) * CP_W'(q_reg[5][1]);
        cpb_reg[2] <= CP_W'(u_reg[5][1]) * CP_W'(q_reg[5][0]);

        for (int i = 0; i < 3; i++)
        begin
            wd_reg[i]  <= WD_W'(cpa_reg[i]) - WD_W'(cpb_reg[i]);
            w_reg[i]   <= W_W'((wd_reg[i] + (WD_W'(1) <<< (UB - 1))) >>> UB);
            qc_reg[i]  <= QC_W'(q_reg[8][i]) * QC_W'(c_reg[8].cs);
            ws_reg[i]  <= WS_W'(w_reg[i]) * WS_W'(c_reg[8].sn);
            tot_reg[i] <= TOT_W'(qc_reg[i]) + TOT_W'(ws_reg[i]);
            res_reg[i] <= RES_W'(p_reg[10][i])
                        + RES_W'((tot_reg[i] + (TOT_W'(1) <<< (UB - 1))) >>> UB);
        end
    end

    always_comb
    begin
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (res_reg[i] > RES_W'(aavr_pkg::COORD_MAX))
            begin
                sat_next[i] = aavr_pkg::COORD_MAX;
                clip_next   = 1'b1;
            end
            else if (res_reg[i] < RES_W'(aavr_pkg::COORD_MIN))
            begin
                sat_next[i] = aavr_pkg::COORD_MIN;
                clip_next   = 1'b1;
            end
            else
            begin
                sat_next[i] = aavr_pkg::coord_t'(res_reg[i]);
            end
        end
    end

    // a zero axis passes the vector through untouched
    always_ff @(posedge clk)
    begin
        zero_reg <= c_reg[NS-2].zero;
        if (c_reg[NS-2].zero)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= a12_arr[i];
            end
            clip_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i] <= sat_next[i];
            end
            clip_reg <= clip_next;
        end
    end

    assign done      = v_reg[NS-1];
    assign rx        = out_reg[0];
    assign ry        = out_reg[1];
    assign rz        = out_reg[2];
    assign axis_zero = zero_reg;
    assign clipped   = clip_reg;

endmodule

// ----- rtl/axis_angle_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// rotates a Q16.16 vector about an arbitrary axis by a fraction of a turn
// ----------------------------------------------------------------------------
// Fully pipelined: a word is taken on every cycle that start is high, busy
// never rises, and each word's result appears on rx/ry/rz with a one-cycle
// done strobe, in input order. The receiver cannot stall, so done must be
// sampled when it comes. The pipeline runs through the sine/cosine cordic
// (one stage per step), the magnitude normalization and sum of squares, the
// 32-stage square root for the axis norm, the 31-stage divider forming the
// unit axis, and 13 stages of projection and blending. A zero axis gives the
// input vector back with axis_zero set.
module axis_angle_vector_rotate #(
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      ax,
    input  logic signed [31:0]      ay,
    input  logic signed [31:0]      az,
    input  logic signed [31:0]      bx,
    input  logic signed [31:0]      by,
    input  logic signed [31:0]      bz,
    input  logic [ANGLE_WIDTH-1:0]  turn,
    output logic                    done,
    output logic signed [31:0]      rx,
    output logic signed [31:0]      ry,
    output logic signed [31:0]      rz,
    output logic                    axis_zero,
    output logic                    clipped
);

`include "axis_angle_vector_rotate_defines.svh"

    localparam int DIV_LAT = 33;

    aavr_pkg::vec_t       a_vec;
    aavr_pkg::vec_t       b_vec;

    logic                 cord_valid;
    aavr_pkg::vec_t       cord_a;
    aavr_pkg::vec_t       cord_b;
    aavr_pkg::coord_t     cord_cs;
    aavr_pkg::coord_t     cord_sn;

    logic                 nrm_valid;
    aavr_pkg::carry_t     nrm_carry;
    aavr_pkg::mag_t       nrm_mag;
    logic [aavr_pkg::SUM_W-1:0] nrm_sum;

    logic                 isq_valid;
    logic [aavr_pkg::NORM_W-1:0] isq_nrm;
    aavr_pkg::carry_t     isq_carry;
    aavr_pkg::mag_t       isq_mag;

    logic                 div_valid;
    aavr_pkg::carry_t     div_carry;
    aavr_pkg::unit_vec_t  div_u;

    assign busy  = 1'b0;
    assign a_vec = '{x: ax, y: ay, z: az};
    assign b_vec = '{x: bx, y: by, z: bz};

    aavr_cordic #(
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .turn      (turn),
        .a_in      (a_vec),
        .b_in      (b_vec),
        .out_valid (cord_valid),
        .a_out     (cord_a),
        .b_out     (cord_b),
        .cs        (cord_cs),
        .sn        (cord_sn)
    );

    aavr_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cord_valid),
        .a_in      (cord_a),
        .b_in      (cord_b),
        .cs        (cord_cs),
        .sn        (cord_sn),
        .out_valid (nrm_valid),
        .carry_out (nrm_carry),
        .mag_out   (nrm_mag),
        .sum_out   (nrm_sum)
    );

    aavr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nrm_valid),
        .sum_in    (nrm_sum),
        .carry_in  (nrm_carry),
        .mag_in    (nrm_mag),
        .out_valid (isq_valid),
        .nrm       (isq_nrm),
        .carry_out (isq_carry),
        .mag_out   (isq_mag)
    );

    aavr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (isq_valid),
        .nrm       (isq_nrm),
        .carry_in  (isq_carry),
        .mag_in    (isq_mag),
        .out_valid (div_valid),
        .carry_out (div_carry),
        .u         (div_u)
    );

    aavr_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .carry_in  (div_carry),
        .u_in      (div_u),
        .done      (done),
        .rx        (rx),
        .ry        (ry),
        .rz        (rz),
        .axis_zero (axis_zero),
        .clipped   (clipped)
    );

    `AAVR_ASSERT_NEVER(a_zero_not_clipped, done && axis_zero && clipped)
    `AAVR_ASSERT_IMPLY(a_clip_at_bound, done && clipped,
        rx == aavr_pkg::COORD_MAX || rx == aavr_pkg::COORD_MIN ||
        ry == aavr_pkg::COORD_MAX || ry == aavr_pkg::COORD_MIN ||
        rz == aavr_pkg::COORD_MAX || rz == aavr_pkg::COORD_MIN)
    `AAVR_ASSERT_IMPLY(a_div_latency, div_valid, $past(isq_valid, DIV_LAT))

endmodule
